/* rtl/argb_unpremultiply_to_bgr_assert.svh */
// Assertion macros shared by the RTL files; the clock is clock and the reset is reset.
`ifndef ARGB_UNPREMULTIPLY_TO_BGR_ASSERT_SVH
`define ARGB_UNPREMULTIPLY_TO_BGR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define AUB_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AUB_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define AUB_ASSERT_NOW(label, ante, cons, msg)
`define AUB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/aub_pkg.sv */
package aub_pkg;

   // Channel layout: lane 0 blue, lane 1 green, lane 2 red
   localparam int CHAN_W    = 8;
   localparam int NUM_LANES = 3;

   // Numerator c*255 + a/2 stays below 2^16
   localparam int NUM_W       = 16;
   // Reciprocal floor(2^16 / a), which is 2^16 for alpha of one
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int TABLE_DEPTH = 1 << CHAN_W;
   // Quotient estimate width
   localparam int EST_W       = NUM_W + RECIP_W - RECIP_SHIFT;
   // Back product q0 * alpha
   localparam int BACK_W      = EST_W + CHAN_W;

   localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'h00;
   localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;

   typedef logic [NUM_LANES-1:0][CHAN_W-1:0] chan_vec_type;

   // Stage one result: numerators and reciprocal
   typedef struct packed {
      logic [CHAN_W-1:0]                alpha;
      chan_vec_type                     chan;
      logic [NUM_LANES-1:0][NUM_W-1:0]  num;
      logic [RECIP_W-1:0]               recip;
   } prep_type;

   // Stage two result: quotient estimates
   typedef struct packed {
      logic [CHAN_W-1:0]                alpha;
      chan_vec_type                     chan;
      logic [NUM_LANES-1:0][NUM_W-1:0]  num;
      logic [NUM_LANES-1:0][EST_W-1:0]  est;
   } est_type;

endpackage

/* rtl/argb_unpremultiply_to_bgr.sv */
// Premultiplied ARGB to straight-alpha BGR converter.
// Input channel: req_valid, req_stall, req_pixel_argb (alpha 31:24, red 23:16,
// green 15:8, blue 7:0). Result channel: rsp_valid, rsp_stall, rsp_blue_out,
// rsp_green_out, rsp_red_out. A transaction moves on a clock edge where valid
// is high and stall is low.
// Each channel becomes round(channel * 255 / alpha), held at 255; alpha zero
// gives black and alpha 255 passes the channels through.
// A pixel moves through three register stages: the reciprocal lookup, the
// estimate multiply, then the remainder check and correction into the output
// register, which drives rsp_valid. Throughput is one pixel per cycle while
// the receiver does not stall.
// When the receiver stalls, the output register holds and the bubbles in the
// earlier stages fill; req_stall rises only once all three stages hold data.
// req_stall depends combinationally on rsp_stall.
// Synchronous reset clears all valid bits; no result is pending after reset.
module argb_unpremultiply_to_bgr (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_argb,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out
);
   import aub_pkg::*;

   `include "argb_unpremultiply_to_bgr_assert.svh"

   logic          prep_valid;
   logic          est_valid;
   logic          prep_adv;
   logic          est_adv;
   logic          out_adv;
   logic          pipe_blocked;
   prep_type      prep_data;
   est_type       est_data;
   chan_vec_type  out_chan;

   // A stage advances when it is empty or the stage after it advances
   assign out_adv   = !rsp_valid || !rsp_stall;
   assign est_adv   = !est_valid || out_adv;
   assign prep_adv  = !prep_valid || est_adv;
   assign req_stall = !prep_adv;

   aub_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (prep_adv),
      .in_valid  (req_valid),
      .in_pixel  (req_pixel_argb),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   aub_estimate u_estimate (
      .clock     (clock),
      .reset     (reset),
      .advance   (est_adv),
      .in_valid  (prep_valid),
      .in_data   (prep_data),
      .out_valid (est_valid),
      .out_data  (est_data)
   );

   aub_correct u_correct (
      .clock     (clock),
      .reset     (reset),
      .advance   (out_adv),
      .in_valid  (est_valid),
      .in_data   (est_data),
      .out_valid (rsp_valid),
      .out_chan  (out_chan)
   );

   assign rsp_blue_out  = out_chan[0];
   assign rsp_green_out = out_chan[1];
   assign rsp_red_out   = out_chan[2];

   // Every stage holds a transaction and the receiver holds off
   assign pipe_blocked = prep_valid && est_valid && rsp_valid && rsp_stall;

   // Input stalls only with a full pipe behind a stalled output
   `AUB_ASSERT_NOW(a_stall_full, req_stall, pipe_blocked, "input stalled with room in the pipe")
   // A blocked first stage keeps its transaction
   `AUB_ASSERT_NEXT(a_prep_hold, prep_valid && !est_adv, prep_valid, "first stage lost its data")

endmodule

/* rtl/aub_prep.sv */
module aub_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [31:0]          in_pixel,
   output logic                 out_valid,
   output aub_pkg::prep_type    out_data
);
   import aub_pkg::*;

   logic [RECIP_W-1:0] recip_tab [TABLE_DEPTH];
   logic               valid_ff;
   logic               valid_in;
   prep_type           data_ff;
   prep_type           data_in;

   // Build the reciprocal table at elaboration
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_recip
      localparam int RecipVal = (i == 0) ? 0 : (RECIP_ONE / ((i == 0) ? 1 : i));
      assign recip_tab[i] = RECIP_W'(RecipVal);
   end

   // Form numerators and look up the reciprocal
   always_comb begin
      data_in.alpha = in_pixel[31:24];
      data_in.chan  = in_pixel[23:0];
      for (int l = 0; l < NUM_LANES; l++) begin
         data_in.num[l] = ({data_in.chan[l], {CHAN_W{1'b0}}} - NUM_W'(data_in.chan[l]))
                          + NUM_W'(data_in.alpha >> 1);
      end
      data_in.recip = recip_tab[data_in.alpha];
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload only when a transaction moves in
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/aub_estimate.sv */
module aub_estimate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  aub_pkg::prep_type    in_data,
   output logic                 out_valid,
   output aub_pkg::est_type     out_data
);
   import aub_pkg::*;

   logic                        valid_ff;
   logic                        valid_in;
   est_type                     data_ff;
   est_type                     data_in;
   logic [NUM_W+RECIP_W-1:0]    prod;

   // Multiply each numerator by the reciprocal, keep the high part
   always_comb begin
      prod          = '0;
      data_in.alpha = in_data.alpha;
      data_in.chan  = in_data.chan;
      data_in.num   = in_data.num;
      for (int l = 0; l < NUM_LANES; l++) begin
         prod = (NUM_W+RECIP_W)'(in_data.num[l]) * (NUM_W+RECIP_W)'(in_data.recip);
         data_in.est[l] = prod[NUM_W+RECIP_W-1:RECIP_SHIFT];
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/aub_correct.sv */
module aub_correct (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  aub_pkg::est_type       in_data,
   output logic                   out_valid,
   output aub_pkg::chan_vec_type  out_chan
);
   import aub_pkg::*;

   `include "argb_unpremultiply_to_bgr_assert.svh"

   logic                          valid_ff;
   logic                          valid_in;
   chan_vec_type                  chan_ff;
   chan_vec_type                  chan_in;
   chan_vec_type                  quot_sat;
   logic [BACK_W-1:0]             back_prod;
   logic [BACK_W-1:0]             rem;
   logic [EST_W-1:0]              quot;
   logic [NUM_LANES-1:0]          rem_ok;

   // Fix the estimate by one where the remainder reaches alpha, then saturate
   always_comb begin
      back_prod = '0;
      rem       = '0;
      quot      = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         back_prod = BACK_W'(in_data.est[l]) * BACK_W'(in_data.alpha);
         rem       = BACK_W'(in_data.num[l]) - back_prod;
         rem_ok[l] = rem < (BACK_W'(in_data.alpha) << 1);
         quot      = in_data.est[l] + EST_W'(rem >= BACK_W'(in_data.alpha));
         quot_sat[l] = (quot > EST_W'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];
      end
   end

   // Select black for zero alpha and the input for full alpha
   always_comb begin
      priority if (in_data.alpha == ALPHA_ZERO) begin
         chan_in = '0;
      end else if (in_data.alpha == ALPHA_FULL) begin
         chan_in = in_data.chan;
      end else begin
         chan_in = quot_sat;
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         chan_ff <= chan_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_chan  = chan_ff;

   // Estimate is the quotient or one below it
   `AUB_ASSERT_NOW(a_rem_bound, in_valid && (in_data.alpha != ALPHA_ZERO), &rem_ok, "quotient estimate off by more than one")
   // Divider path alone reproduces the channel at full alpha
   `AUB_ASSERT_NOW(a_full_alpha, in_valid && (in_data.alpha == ALPHA_FULL), quot_sat == in_data.chan, "divider path wrong at full alpha")

endmodule
